>>> rtl/core/spi_flash_program_erase_sequencer_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef SPI_FLASH_PROGRAM_ERASE_SEQUENCER_MACROS_SVH
`define SPI_FLASH_PROGRAM_ERASE_SEQUENCER_MACROS_SVH

// Condition must imply expression on the same clock edge.
`define SFPES_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Expression must hold on every clock edge outside reset.
`define SFPES_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

>>> rtl/core/sfpes_pkg.sv
// Shared types, codes and micro-sequence table of the flash program/erase sequencer.
package sfpes_pkg;

  localparam logic [24:0] FLASH_BYTES = 25'd8388608;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [21:0] BUSY_POLL_LIMIT_RESET  = 22'd4000000;
  localparam logic [4:0]  WREN_RETRY_LIMIT_RESET = 5'd16;

  localparam int unsigned CFG_DATA_BITS = 22;
  localparam logic        CFG_BUSY_POLL_LIMIT  = 1'b0;
  localparam logic        CFG_WREN_RETRY_LIMIT = 1'b1;

  localparam logic [1:0] REQ_ERASE   = 2'd0;
  localparam logic [1:0] REQ_PROGRAM = 2'd1;
  localparam logic [1:0] REQ_DATA    = 2'd2;
  localparam logic [1:0] REQ_STATUS  = 2'd3;

  localparam int unsigned SR_WIP_BIT = 0;
  localparam int unsigned SR_WEL_BIT = 1;

  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_PP4  = 8'h38;
  localparam logic [7:0] OP_SE   = 8'h20;

  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_TIMEOUT  = 2'd1;
  localparam logic [1:0] RC_INVALID  = 2'd2;
  localparam logic [1:0] RC_REJECTED = 2'd3;

  typedef enum logic [3:0] {
    ACT_LEAVE_AUTO  = 4'd0,
    ACT_ENTER_AUTO  = 4'd1,
    ACT_SINGLE      = 4'd2,
    ACT_QUAD        = 4'd3,
    ACT_SELECT      = 4'd4,
    ACT_DESELECT    = 4'd5,
    ACT_SEND        = 4'd6,
    ACT_EXIT_WORD   = 4'd7,
    ACT_READ_STATUS = 4'd8,
    ACT_DONE        = 4'd9
  } action_t;

  // Where the byte of a send step comes from.
  typedef enum logic [3:0] {
    SRC_NONE     = 4'd0,
    SRC_RDSR     = 4'd1,
    SRC_WREN     = 4'd2,
    SRC_PP4      = 4'd3,
    SRC_SE       = 4'd4,
    SRC_ADDR_HI  = 4'd5,
    SRC_ADDR_MID = 4'd6,
    SRC_ADDR_LO  = 4'd7,
    SRC_DATA     = 4'd8
  } src_t;

  // Bus sequences the back end plays out, one per accepted item.
  typedef enum logic [3:0] {
    SEQ_FAIL      = 4'd0,
    SEQ_START     = 4'd1,
    SEQ_POLL      = 4'd2,
    SEQ_FINISH    = 4'd3,
    SEQ_WREN      = 4'd4,
    SEQ_PROGRAM   = 4'd5,
    SEQ_ERASE     = 4'd6,
    SEQ_DATA      = 4'd7,
    SEQ_DATA_LAST = 4'd8
  } seq_t;

  localparam int unsigned STEP_BITS = 4;

  typedef struct packed {
    seq_t        seq;
    logic [1:0]  code;
    logic [7:0]  data;
    logic [23:0] addr;
  } cmd_t;

  typedef struct packed {
    action_t action;
    src_t    src;
    logic    last;
  } step_t;

  function automatic step_t mk_step(action_t a, src_t s, logic l);
    step_t r;
    r.action = a;
    r.src    = s;
    r.last   = l;
    return r;
  endfunction

  function automatic step_t seq_step(seq_t seq, logic [STEP_BITS-1:0] idx);
    step_t r;
    r = mk_step(ACT_DONE, SRC_NONE, 1'b1);
    case (seq)
      SEQ_FAIL: r = mk_step(ACT_DONE, SRC_NONE, 1'b1);
      SEQ_START: begin
        case (idx)
          4'd0: r = mk_step(ACT_LEAVE_AUTO, SRC_NONE, 1'b0);
          4'd1: r = mk_step(ACT_QUAD, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd3: r = mk_step(ACT_EXIT_WORD, SRC_NONE, 1'b0);
          4'd4: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd5: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd6: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd7: r = mk_step(ACT_SEND, SRC_RDSR, 1'b0);
          default: r = mk_step(ACT_READ_STATUS, SRC_NONE, 1'b1);
        endcase
      end
      SEQ_POLL: begin
        case (idx)
          4'd0: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd1: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd3: r = mk_step(ACT_SEND, SRC_RDSR, 1'b0);
          default: r = mk_step(ACT_READ_STATUS, SRC_NONE, 1'b1);
        endcase
      end
      SEQ_FINISH: begin
        case (idx)
          4'd0: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd1: r = mk_step(ACT_QUAD, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_ENTER_AUTO, SRC_NONE, 1'b0);
          default: r = mk_step(ACT_DONE, SRC_NONE, 1'b1);
        endcase
      end
      SEQ_WREN: begin
        case (idx)
          4'd0: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd1: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd3: r = mk_step(ACT_SEND, SRC_WREN, 1'b0);
          4'd4: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd5: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd6: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd7: r = mk_step(ACT_SEND, SRC_RDSR, 1'b0);
          default: r = mk_step(ACT_READ_STATUS, SRC_NONE, 1'b1);
        endcase
      end
      SEQ_PROGRAM: begin
        case (idx)
          4'd0: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd1: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd3: r = mk_step(ACT_SEND, SRC_PP4, 1'b0);
          4'd4: r = mk_step(ACT_QUAD, SRC_NONE, 1'b0);
          4'd5: r = mk_step(ACT_SEND, SRC_ADDR_HI, 1'b0);
          4'd6: r = mk_step(ACT_SEND, SRC_ADDR_MID, 1'b0);
          default: r = mk_step(ACT_SEND, SRC_ADDR_LO, 1'b1);
        endcase
      end
      SEQ_ERASE: begin
        case (idx)
          4'd0:  r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd1:  r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd2:  r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd3:  r = mk_step(ACT_SEND, SRC_SE, 1'b0);
          4'd4:  r = mk_step(ACT_SEND, SRC_ADDR_HI, 1'b0);
          4'd5:  r = mk_step(ACT_SEND, SRC_ADDR_MID, 1'b0);
          4'd6:  r = mk_step(ACT_SEND, SRC_ADDR_LO, 1'b0);
          4'd7:  r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd8:  r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd9:  r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd10: r = mk_step(ACT_SEND, SRC_RDSR, 1'b0);
          default: r = mk_step(ACT_READ_STATUS, SRC_NONE, 1'b1);
        endcase
      end
      SEQ_DATA: r = mk_step(ACT_SEND, SRC_DATA, 1'b1);
      SEQ_DATA_LAST: begin
        case (idx)
          4'd0: r = mk_step(ACT_SEND, SRC_DATA, 1'b0);
          4'd1: r = mk_step(ACT_DESELECT, SRC_NONE, 1'b0);
          4'd2: r = mk_step(ACT_SINGLE, SRC_NONE, 1'b0);
          4'd3: r = mk_step(ACT_SELECT, SRC_NONE, 1'b0);
          4'd4: r = mk_step(ACT_SEND, SRC_RDSR, 1'b0);
          default: r = mk_step(ACT_READ_STATUS, SRC_NONE, 1'b1);
        endcase
      end
      default: r = mk_step(ACT_DONE, SRC_NONE, 1'b1);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/sfpes_front.sv
// Front end: accepts items, tracks the operation phase and limits, emits commands.
module sfpes_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic [sfpes_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic [1:0]                            req_type,
  input  logic [23:0]                           address,
  input  logic [7:0]                            data_byte,
  input  logic [7:0]                            status_byte,
  input  logic                                  last,
  input  logic                                  q_full,
  output logic                                  push,
  output sfpes_pkg::cmd_t                       cmd
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_WAIT_BUSY = 5'b00010,
    PH_WREN      = 5'b00100,
    PH_DATA      = 5'b01000,
    PH_WAIT_DONE = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [21:0] poll_count, poll_count_next;
  logic [4:0]  wren_count, wren_count_next;
  logic        is_program, is_program_next;
  logic [23:0] target_address, target_address_next;
  logic [21:0] busy_poll_limit;
  logic [4:0]  wren_retry_limit;
  logic        wip, wel, is_request;

  assign item_ready = !q_full;
  assign push       = item_valid && item_ready;
  assign wip        = status_byte[sfpes_pkg::SR_WIP_BIT];
  assign wel        = status_byte[sfpes_pkg::SR_WEL_BIT];
  assign is_request = (req_type == sfpes_pkg::REQ_ERASE) ||
                      (req_type == sfpes_pkg::REQ_PROGRAM);

  always_comb begin
    phase_next          = phase;
    poll_count_next     = poll_count;
    wren_count_next     = wren_count;
    is_program_next     = is_program;
    target_address_next = target_address;
    cmd.seq             = sfpes_pkg::SEQ_FAIL;
    cmd.code            = sfpes_pkg::RC_REJECTED;
    cmd.data            = data_byte;
    cmd.addr            = target_address;
    case (phase)
      PH_IDLE: begin
        if (is_request) begin
          if ({1'b0, address} >= sfpes_pkg::FLASH_BYTES) begin
            cmd.code = sfpes_pkg::RC_INVALID;
          end else begin
            cmd.seq             = sfpes_pkg::SEQ_START;
            cmd.code            = sfpes_pkg::RC_OK;
            is_program_next     = (req_type == sfpes_pkg::REQ_PROGRAM);
            target_address_next = address;
            poll_count_next     = 22'd1;
            phase_next          = PH_WAIT_BUSY;
          end
        end
      end
      PH_WAIT_BUSY, PH_WAIT_DONE: begin
        if (req_type == sfpes_pkg::REQ_STATUS) begin
          cmd.code = sfpes_pkg::RC_OK;
          if (!wip) begin
            if (phase == PH_WAIT_BUSY) begin
              cmd.seq         = sfpes_pkg::SEQ_WREN;
              wren_count_next = 5'd1;
              phase_next      = PH_WREN;
            end else begin
              cmd.seq    = sfpes_pkg::SEQ_FINISH;
              phase_next = PH_IDLE;
            end
          end else if (poll_count >= busy_poll_limit) begin
            cmd.seq    = sfpes_pkg::SEQ_FINISH;
            cmd.code   = sfpes_pkg::RC_TIMEOUT;
            phase_next = PH_IDLE;
          end else begin
            cmd.seq         = sfpes_pkg::SEQ_POLL;
            poll_count_next = poll_count + 22'd1;
          end
        end
      end
      PH_WREN: begin
        if (req_type == sfpes_pkg::REQ_STATUS) begin
          cmd.code = sfpes_pkg::RC_OK;
          if (wel) begin
            if (is_program) begin
              cmd.seq    = sfpes_pkg::SEQ_PROGRAM;
              phase_next = PH_DATA;
            end else begin
              cmd.seq         = sfpes_pkg::SEQ_ERASE;
              poll_count_next = 22'd1;
              phase_next      = PH_WAIT_DONE;
            end
          end else if (wren_count >= wren_retry_limit) begin
            cmd.seq    = sfpes_pkg::SEQ_FINISH;
            cmd.code   = sfpes_pkg::RC_TIMEOUT;
            phase_next = PH_IDLE;
          end else begin
            cmd.seq         = sfpes_pkg::SEQ_WREN;
            wren_count_next = wren_count + 5'd1;
          end
        end
      end
      PH_DATA: begin
        if (req_type == sfpes_pkg::REQ_DATA) begin
          cmd.code = sfpes_pkg::RC_OK;
          if (last) begin
            cmd.seq         = sfpes_pkg::SEQ_DATA_LAST;
            poll_count_next = 22'd1;
            phase_next      = PH_WAIT_DONE;
          end else begin
            cmd.seq = sfpes_pkg::SEQ_DATA;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      poll_count       <= '0;
      wren_count       <= '0;
      is_program       <= 1'b0;
      target_address   <= '0;
      busy_poll_limit  <= sfpes_pkg::BUSY_POLL_LIMIT_RESET;
      wren_retry_limit <= sfpes_pkg::WREN_RETRY_LIMIT_RESET;
    end else begin
      if (push) begin
        phase          <= phase_next;
        poll_count     <= poll_count_next;
        wren_count     <= wren_count_next;
        is_program     <= is_program_next;
        target_address <= target_address_next;
      end
      if (cfg_write) begin
        if (cfg_index == sfpes_pkg::CFG_BUSY_POLL_LIMIT) begin
          busy_poll_limit <= cfg_data;
        end else begin
          wren_retry_limit <= cfg_data[4:0];
        end
      end
    end
  end

endmodule

>>> rtl/core/sfpes_queue.sv
// Short command queue between the front and back ends.
`include "spi_flash_program_erase_sequencer_macros.svh"

module sfpes_queue #(
  parameter int unsigned DEPTH = sfpes_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfpes_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            head_valid,
  output sfpes_pkg::cmd_t head_cmd,
  input  logic            pop
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  sfpes_pkg::cmd_t     entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = (count == CNT_BITS'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  `SFPES_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_BITS'(DEPTH), "queue overfilled")
  `SFPES_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, head_valid, "pop from empty queue")

endmodule

>>> rtl/core/sfpes_back.sv
// Back end: plays each command out as bus actions through an output register.
`include "spi_flash_program_erase_sequencer_macros.svh"

module sfpes_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  sfpes_pkg::cmd_t head_cmd,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [3:0]      action,
  output logic [7:0]      byte_out,
  output logic [1:0]      result_code,
  output logic            final_of_run
);

  logic                             cmd_valid;
  sfpes_pkg::cmd_t                  cmd;
  logic [sfpes_pkg::STEP_BITS-1:0]  idx;
  sfpes_pkg::step_t                 step;
  logic                             advance;
  logic [7:0]                       step_byte;

  assign step    = sfpes_pkg::seq_step(cmd.seq, idx);
  assign advance = cmd_valid && (!result_valid || result_ready);
  assign pop     = head_valid && (!cmd_valid || (advance && step.last));

  always_comb begin
    case (step.src)
      sfpes_pkg::SRC_RDSR:     step_byte = sfpes_pkg::OP_RDSR;
      sfpes_pkg::SRC_WREN:     step_byte = sfpes_pkg::OP_WREN;
      sfpes_pkg::SRC_PP4:      step_byte = sfpes_pkg::OP_PP4;
      sfpes_pkg::SRC_SE:       step_byte = sfpes_pkg::OP_SE;
      sfpes_pkg::SRC_ADDR_HI:  step_byte = cmd.addr[23:16];
      sfpes_pkg::SRC_ADDR_MID: step_byte = cmd.addr[15:8];
      sfpes_pkg::SRC_ADDR_LO:  step_byte = cmd.addr[7:0];
      sfpes_pkg::SRC_DATA:     step_byte = cmd.data;
      default:                 step_byte = 8'h00;
    endcase
  end

  // Load the next command in the cycle the current one emits its last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cmd_valid <= 1'b1;
      idx       <= '0;
    end else if (advance) begin
      if (step.last) begin
        cmd_valid <= 1'b0;
      end else begin
        idx <= idx + sfpes_pkg::STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action       <= step.action;
      byte_out     <= step_byte;
      result_code  <= (step.action == sfpes_pkg::ACT_DONE) ? cmd.code : sfpes_pkg::RC_OK;
      final_of_run <= step.last;
    end
  end

  `SFPES_ASSERT_IMP(a_code_only_done, clk, rst,
    result_valid && (action != sfpes_pkg::ACT_DONE), result_code == sfpes_pkg::RC_OK,
    "result code set on a non-done action")
  `SFPES_ASSERT_IMP(a_done_is_final, clk, rst,
    result_valid && (action == sfpes_pkg::ACT_DONE), final_of_run,
    "done action not marked final")

endmodule

>>> rtl/core/spi_flash_program_erase_sequencer.sv
// Quad SPI NOR flash program/erase sequencer, top level.
//
// Input channel (item_valid/item_ready): erase or program requests, program
// data bytes and flash status bytes. Each item produces one to twelve bus
// actions on the result channel (result_valid/result_ready), the last one
// flagged by final_of_run; a done action carries the outcome code.
// Configuration: cfg_write with cfg_index 0 sets the busy poll limit, index 1
// the write enable retry limit; write only while the block is idle.
// Each item's command passes the queue and the back-end command register.
// Throughput: one action per cycle from the back-end step counter while commands
// are queued and result_ready stays high. The front end takes
// an item per cycle until the command queue (QUEUE_DEPTH entries) fills.
// Reset: phase returns to idle, counters clear, limits return to 4000000 and
// 16, queue and output register empty.
// Stall: while result_ready is low the output register holds its action, the
// back end waits, and the queue absorbs further items before item_ready drops.
module spi_flash_program_erase_sequencer #(
  parameter int unsigned QUEUE_DEPTH = sfpes_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sfpes_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [1:0]                          req_type,
  input  logic [23:0]                         address,
  input  logic [7:0]                          data_byte,
  input  logic [7:0]                          status_byte,
  input  logic                                last,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [3:0]                          action,
  output logic [7:0]                          byte_out,
  output logic [1:0]                          result_code,
  output logic                                final_of_run
);

  logic            q_full, push, head_valid, pop;
  sfpes_pkg::cmd_t push_cmd, head_cmd;

  sfpes_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .req_type    (req_type),
    .address     (address),
    .data_byte   (data_byte),
    .status_byte (status_byte),
    .last        (last),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  sfpes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  sfpes_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .action       (action),
    .byte_out     (byte_out),
    .result_code  (result_code),
    .final_of_run (final_of_run)
  );

endmodule
